FILE: rtl/stack_with_remove_by_key_macros.svh
// ----------------------------------------------------------------------------
// Stack with remove by key: assertion macros
// Concurrent assertion shorthands clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef STACK_WITH_REMOVE_BY_KEY_MACROS_SVH
`define STACK_WITH_REMOVE_BY_KEY_MACROS_SVH

// same-cycle implication
`define SWRK_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swrk: same-cycle check failed");

// next-cycle implication
`define SWRK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swrk: next-cycle check failed");

`endif

FILE: rtl/swrk_pkg.sv
// ----------------------------------------------------------------------------
// Stack with remove by key: package
// Field widths, operation and status codes, controller states, cell control.
// ----------------------------------------------------------------------------
package swrk_pkg;

  localparam int unsigned FUNC_W   = 1;
  localparam int unsigned CAR_ID_W = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  localparam logic [FUNC_W-1:0] FUNC_PARK     = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_RETRIEVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } swrk_state_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

FILE: rtl/swrk_if.sv
// ----------------------------------------------------------------------------
// Stack with remove by key: channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface swrk_req_if
  import swrk_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [CAR_ID_W-1:0] car_id;

  modport source (output valid, output func, output car_id, input ready);
  modport sink   (input valid, input func, input car_id, output ready);
endinterface

interface swrk_rsp_if
  import swrk_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  occupancy;
  logic [COUNT_W-1:0]  cars_above;

  modport source (output valid, output status, output occupancy, output cars_above,
                  input ready);
  modport sink   (input valid, input status, input occupancy, input cars_above,
                  output ready);
endinterface

FILE: rtl/swrk_cell.sv
// ----------------------------------------------------------------------------
// Stack with remove by key: lane cell
// One slot of the lane; loads a new identifier or takes its upper neighbor.
// ----------------------------------------------------------------------------
module swrk_cell
  import swrk_pkg::*;
#(
  parameter int ID_BITS = 16
) (
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic [ID_BITS-1:0] wr_id,
  input  logic [ID_BITS-1:0] up_id,
  input  logic [ID_BITS-1:0] key,
  output logic [ID_BITS-1:0] slot,
  output logic               hit
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      slot <= wr_id;
    end else if (ctrl.shift) begin
      slot <= up_id;
    end
  end

  assign hit = (slot == key);

endmodule

FILE: rtl/stack_with_remove_by_key.sv
// ----------------------------------------------------------------------------
// Stack with remove by key
// Bounded LIFO lane of identifiers with removal of the topmost matching entry.
//
// Channels: req carries func (park or retrieve) and car_id; rsp returns one
// transaction per request with status, occupancy and cars_above.
// Only the low ID_BITS bits of car_id are stored and compared.
// Once a park is accepted, its result is written from S_FINISH. A retrieve
// first scans the cell chain one slot per cycle from the top down, stopping
// at the first hit or at the bottom slot (no scan on an empty lane).
// Requests are taken one at a time; req is ready again from the edge that
// loads the result into the output register.
// Removal shifts every cell above the hit down by one together, on the edge that writes the result.
// Reset: the lane is empty; slot contents are left as they are.
// Stall: the result holds in the output register while rsp.ready is low; the
// next request is accepted and worked on meanwhile, and waits to write its
// result (and update the lane) until the register is free.
// ----------------------------------------------------------------------------
module stack_with_remove_by_key
  import swrk_pkg::*;
#(
  parameter int DEPTH   = 16,
  parameter int ID_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  swrk_req_if.sink   req,
  swrk_rsp_if.source rsp
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  swrk_state_t        state, state_next;
  logic [CNT_W-1:0]   fill, fill_next;
  logic [IDX_W-1:0]   k, k_next;
  logic               found, found_next;
  logic [FUNC_W-1:0]  func_q, func_q_next;
  logic [ID_BITS-1:0] key, key_next;

  logic                rsp_valid, rsp_valid_next;
  logic [STATUS_W-1:0] status_q, status_q_next;
  logic [COUNT_W-1:0]  occ_q, occ_q_next;
  logic [COUNT_W-1:0]  above_q, above_q_next;

  logic [ID_BITS-1:0] slot [DEPTH];
  logic [DEPTH-1:0]   hit;
  cell_ctrl_t         ctrl [DEPTH];

  logic                  fire;
  logic                  full;
  logic [CNT_W-1:0]      fill_m1;
  logic [CNT_W-1:0]      above_cnt;
  logic [ID_BITS+CAR_ID_W-1:0] id_ext;
  logic [CNT_W+COUNT_W-1:0]    occ_ext;
  logic [CNT_W+COUNT_W-1:0]    above_ext;

  assign full      = (fill == CNT_W'(DEPTH));
  assign fill_m1   = fill - 1'b1;
  assign above_cnt = fill_m1 - CNT_W'(k);
  assign id_ext    = {{ID_BITS{1'b0}}, req.car_id};
  assign fire      = (state == S_FINISH) && (!rsp_valid || rsp.ready);

  assign req.ready = (state == S_IDLE) && !rst;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ID_BITS-1:0] up_id;
    if (i == DEPTH - 1) begin : g_top
      assign up_id = slot[i];
    end else begin : g_mid
      assign up_id = slot[i+1];
    end

    assign ctrl[i].load  = fire && (func_q == FUNC_PARK) && !full && (fill == CNT_W'(i));
    assign ctrl[i].shift = fire && (func_q == FUNC_RETRIEVE) && found &&
                           (IDX_W'(i) >= k);

    swrk_cell #(.ID_BITS(ID_BITS)) u_cell (
      .clk   (clk),
      .ctrl  (ctrl[i]),
      .wr_id (key),
      .up_id (up_id),
      .key   (key),
      .slot  (slot[i]),
      .hit   (hit[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      rsp_valid <= rsp_valid_next;
    end
    k        <= k_next;
    found    <= found_next;
    func_q   <= func_q_next;
    key      <= key_next;
    status_q <= status_q_next;
    occ_q    <= occ_q_next;
    above_q  <= above_q_next;
  end

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    k_next         = k;
    found_next     = found;
    func_q_next    = func_q;
    key_next       = key;
    rsp_valid_next = rsp_valid && !rsp.ready;
    status_q_next  = status_q;
    occ_q_next     = occ_q;
    above_q_next   = above_q;
    occ_ext        = '0;
    above_ext      = '0;

    case (state)
      S_IDLE: begin
        if (req.valid && req.ready) begin
          func_q_next = req.func;
          key_next    = id_ext[ID_BITS-1:0];
          found_next  = 1'b0;
          k_next      = fill_m1[IDX_W-1:0];
          if (req.func == FUNC_RETRIEVE && fill != '0) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_SCAN: begin
        if (hit[k]) begin
          found_next = 1'b1;
          state_next = S_FINISH;
        end else if (k == '0) begin
          state_next = S_FINISH;
        end else begin
          k_next = k - 1'b1;
        end
      end
      S_FINISH: begin
        if (fire) begin
          rsp_valid_next = 1'b1;
          state_next     = S_IDLE;
          if (func_q == FUNC_PARK) begin
            if (full) begin
              status_q_next = ST_FULL;
            end else begin
              status_q_next = ST_DONE;
              fill_next     = fill + 1'b1;
            end
          end else if (found) begin
            status_q_next = ST_DONE;
            fill_next     = fill_m1;
            above_ext     = {{COUNT_W{1'b0}}, above_cnt};
          end else begin
            status_q_next = ST_MISSING;
          end
          occ_ext      = {{COUNT_W{1'b0}}, fill_next};
          occ_q_next   = occ_ext[COUNT_W-1:0];
          above_q_next = above_ext[COUNT_W-1:0];
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.status     = status_q;
  assign rsp.occupancy  = occ_q;
  assign rsp.cars_above = above_q;

endmodule

FILE: rtl/swrk_checker.sv
// ----------------------------------------------------------------------------
// Stack with remove by key: port checker
// Checks response coding and request sequencing seen at the top-level ports.
// ----------------------------------------------------------------------------
`include "stack_with_remove_by_key_macros.svh"

module swrk_checker
  import swrk_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [STATUS_W-1:0] status,
  input logic [COUNT_W-1:0]  cars_above
);

  `SWRK_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status))
  `SWRK_ASSERT_NOW(a_status_code, rsp_valid, status == ST_DONE || status == ST_FULL || status == ST_MISSING)
  `SWRK_ASSERT_NOW(a_above_on_fail, rsp_valid && status != ST_DONE, cars_above == '0)
  `SWRK_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)

endmodule

bind stack_with_remove_by_key swrk_checker u_swrk_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .status     (rsp.status),
  .cars_above (rsp.cars_above)
);
